// ===== rtl/mwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mwsd_pkg: shared types and constants
// Widths, register indexes and state types of the moving window std-dev block.
// ----------------------------------------------------------------------------
package mwsd_pkg;

   localparam int MAX_WINDOW   = 32;
   localparam int SAMPLE_WIDTH = 24;
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int N_W          = IDX_W + 1;
   localparam int SQ_W         = 2 * SAMPLE_WIDTH;
   localparam int SUM_W        = SAMPLE_WIDTH + N_W;
   localparam int SUMSQ_W      = SQ_W + N_W - 1;
   localparam int NSS_W        = SUMSQ_W + N_W;
   localparam int S1SQ_W       = 2 * (SUM_W - 1);
   localparam int RAD_W        = 60;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int STEP_W       = $clog2(ROOT_W);
   localparam int STD_W        = 23;
   localparam int CNT_W        = IDX_W;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = N_W;

   localparam logic [CSR_IDX_W-1:0] REG_ERR_MODE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQV,
      ST_FILL,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_PUSH_C,
      ST_DECIDE,
      ST_FLUSH_CHK,
      ST_STD_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DIFF,
      PH_ROOT,
      PH_DIV,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/mwsd_cell.sv =====
// ----------------------------------------------------------------------------
// mwsd_cell: one window cell
// Holds one sample; loads the series start value or takes its neighbor's.
// ----------------------------------------------------------------------------
module mwsd_cell (
   input  logic                                       clock,
   input  mwsd_pkg::cell_ctrl_type                    ctrl,
   input  logic signed [mwsd_pkg::SAMPLE_WIDTH-1:0]   load_data,
   input  logic signed [mwsd_pkg::SAMPLE_WIDTH-1:0]   shift_in,
   output logic signed [mwsd_pkg::SAMPLE_WIDTH-1:0]   q
);

   logic signed [mwsd_pkg::SAMPLE_WIDTH-1:0] q_ff, q_in;

   always_comb begin
      q_in = q_ff;
      if (ctrl.load) begin
         q_in = load_data;
      end else if (ctrl.shift) begin
         q_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ===== rtl/mwsd_std.sv =====
// ----------------------------------------------------------------------------
// mwsd_std: standard deviation unit
// Forms N*S2 - S1^2, takes its square root a bit a cycle, divides by N.
// ----------------------------------------------------------------------------
module mwsd_std (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [mwsd_pkg::N_W-1:0]             n,
   input  logic signed [mwsd_pkg::SUM_W-1:0]    s1,
   input  logic [mwsd_pkg::SUMSQ_W-1:0]         s2,
   output logic                                 done,
   output logic [mwsd_pkg::STD_W-1:0]           result
);

   localparam int RW = mwsd_pkg::RAD_W;
   localparam int QW = mwsd_pkg::ROOT_W;

   mwsd_pkg::phase_type ph_ff, ph_in;
   logic [mwsd_pkg::NSS_W-1:0]   ns2_ff, ns2_in;
   logic [mwsd_pkg::S1SQ_W-1:0]  s1sq_ff, s1sq_in;
   logic [RW-1:0]                x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [mwsd_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [QW-1:0]                quo_ff, quo_in;
   logic [mwsd_pkg::IDX_W-1:0]   rem_ff, rem_in;

   logic [mwsd_pkg::SUM_W-1:0]   s1_mag;
   logic [2*mwsd_pkg::SUM_W-1:0] s1_prod;
   logic [mwsd_pkg::NSS_W+1:0]   ns2_prod;
   logic [RW-1:0]                trial, res_step;
   logic                         root_ge, div_ge;
   logic [mwsd_pkg::N_W-1:0]     rem_shift;

   always_comb begin
      s1_mag   = s1[mwsd_pkg::SUM_W-1] ? (~s1 + 1'b1) : s1;
      s1_prod  = s1_mag * s1_mag;
      ns2_prod = {2'b00, s2} * {{(mwsd_pkg::NSS_W-mwsd_pkg::N_W+2){1'b0}}, n};
      trial    = res_ff + bit_ff;
      root_ge  = x_ff >= trial;
      res_step = root_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      rem_shift = {rem_ff, quo_ff[QW-1]};
      div_ge   = rem_shift >= n;
   end

   always_comb begin
      ph_in   = ph_ff;
      ns2_in  = ns2_ff;
      s1sq_in = s1sq_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      case (ph_ff)
         mwsd_pkg::PH_IDLE: begin
            if (start) begin
               ns2_in  = ns2_prod[mwsd_pkg::NSS_W-1:0];
               s1sq_in = s1_prod[mwsd_pkg::S1SQ_W-1:0];
               ph_in   = mwsd_pkg::PH_DIFF;
            end
         end
         mwsd_pkg::PH_DIFF: begin
            // Guard against a negative radicand.
            if ({1'b0, ns2_ff} >= {2'b00, s1sq_ff}) begin
               x_in = RW'({1'b0, ns2_ff} - {2'b00, s1sq_ff});
            end else begin
               x_in = '0;
            end
            res_in = '0;
            bit_in = RW'(1) << (RW - 2);
            cnt_in = '0;
            ph_in  = mwsd_pkg::PH_ROOT;
         end
         mwsd_pkg::PH_ROOT: begin
            if (root_ge) begin
               x_in = x_ff - trial;
            end
            res_in = res_step;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mwsd_pkg::STEP_W'(QW - 1)) begin
               quo_in = res_step[QW-1:0];
               rem_in = '0;
               cnt_in = '0;
               ph_in  = mwsd_pkg::PH_DIV;
            end
         end
         mwsd_pkg::PH_DIV: begin
            rem_in = div_ge ? mwsd_pkg::IDX_W'(rem_shift - n)
                            : rem_shift[mwsd_pkg::IDX_W-1:0];
            quo_in = {quo_ff[QW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mwsd_pkg::STEP_W'(QW - 1)) begin
               ph_in = mwsd_pkg::PH_DONE;
            end
         end
         mwsd_pkg::PH_DONE: begin
            ph_in = mwsd_pkg::PH_IDLE;
         end
         default: begin
            ph_in = mwsd_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= mwsd_pkg::PH_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
      ns2_ff  <= ns2_in;
      s1sq_ff <= s1sq_in;
      x_ff    <= x_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done   = (ph_ff == mwsd_pkg::PH_DONE);
   assign result = quo_ff[mwsd_pkg::STD_W-1:0];

endmodule

// ===== rtl/moving_window_std_dev.sv =====
// ----------------------------------------------------------------------------
// moving_window_std_dev: sliding window standard deviation
// Emits, per series position, the population std-dev of an N sample window.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one Q16.8 sample per request; req_tlast closes a series.
//  - rsp_* carries one std-dev per position; rsp_tlast marks the last result
//    caused by a request, rsp_tuser marks the result of the final position.
//  - csr_* writes err_mode (index 0) and window_length (index 1); the user
//    must do so only while idle, not enforced by the block. N is latched at
//    series start; 0 reads as 1, above 32 as 32. err_mode 0 drops requests.
//  - One request at a time: a request passes through the window update and,
//    when it yields a result, through the std-dev unit (30 square root
//    steps, 30 divide steps, setup), plus the wait for rsp_tready.
//    The closing request emits up to N-N/2 results, each after its own
//    window shifts and std-dev pass. Results lag their position by
//    N-1-N/2 requests.
//  - req_tready stays low while a result waits in the output register; a
//    stalled receiver holds the block without losing anything.
//  - Reset (synchronous) clears the series and the sums, leaving the window
//    cells as they are, and restores err_mode 0 and window_length 5.
// ----------------------------------------------------------------------------
module moving_window_std_dev (
   input  logic                                clock,
   input  logic                                reset,
   // sample [23:0]
   input  logic [23:0]                         req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // std_dev [22:0], zero [23]
   output logic [23:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [mwsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mwsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SW = mwsd_pkg::SAMPLE_WIDTH;
   localparam int MW = mwsd_pkg::MAX_WINDOW;
   localparam int NW = mwsd_pkg::N_W;
   localparam int CW = mwsd_pkg::CNT_W;

   mwsd_pkg::state_type state_ff, state_in;

   logic                          err_mode_ff, err_mode_in;
   logic [NW-1:0]                 win_len_ff, win_len_in;
   logic [NW-1:0]                 n_ff, n_in;
   logic signed [SW-1:0]          v_ff, v_in, old_ff, old_in;
   logic                          last_ff, last_in;
   logic [mwsd_pkg::SQ_W-1:0]     sqv_ff, sqv_in, sqo_ff, sqo_in;
   logic signed [mwsd_pkg::SUM_W-1:0] s1_ff, s1_in;
   logic [mwsd_pkg::SUMSQ_W-1:0]  s2_ff, s2_in;
   logic                          started_ff, started_in, flushing_ff, flushing_in;
   logic [CW-1:0]                 pending_ff, pending_in, back_ff, back_in;
   logic [CW-1:0]                 shifts_ff, shifts_in;
   logic [mwsd_pkg::STD_W-1:0]    out_ff, out_in;
   logic                          olast_ff, olast_in, oend_ff, oend_in;

   logic                          accept, std_start, std_done;
   logic [mwsd_pkg::STD_W-1:0]    std_result;
   mwsd_pkg::cell_ctrl_type       cell_ctrl;
   logic signed [SW-1:0]          cell_q [MW];
   logic [NW-1:0]                 lag_full, n_clamped, tail_idx;
   logic [CW-1:0]                 lag, need;
   logic [SW-1:0]                 mag_v, mag_old;
   logic [2*SW-1:0]               sq_v, sq_old;
   logic signed [SW+NW:0]         fill_s1;
   logic [mwsd_pkg::SQ_W+NW-1:0]  fill_s2;

   // Window cells: a load puts the new sample in every cell; a shift puts it in cell 0, each further cell its neighbor.
   for (genvar i = 0; i < MW; i++) begin : g_cell
      if (i == 0) begin : g_head
         mwsd_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .load_data (v_ff),
            .shift_in  (v_ff),
            .q         (cell_q[i])
         );
      end else begin : g_tail
         mwsd_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .load_data (v_ff),
            .shift_in  (cell_q[i-1]),
            .q         (cell_q[i])
         );
      end
   end

   mwsd_std u_std (
      .clock  (clock),
      .reset  (reset),
      .start  (std_start),
      .n      (n_ff),
      .s1     (s1_ff),
      .s2     (s2_ff),
      .done   (std_done),
      .result (std_result)
   );

   always_comb begin
      accept    = req_tvalid && req_tready;
      lag_full  = n_ff - NW'(1) - (n_ff >> 1);
      lag       = lag_full[CW-1:0];
      need      = (lag > back_ff) ? (lag - back_ff) : '0;
      tail_idx  = n_ff - NW'(1);
      if (win_len_ff == '0) begin
         n_clamped = NW'(1);
      end else if (win_len_ff > NW'(MW)) begin
         n_clamped = NW'(MW);
      end else begin
         n_clamped = win_len_ff;
      end
      mag_v   = v_ff[SW-1] ? SW'(~v_ff + 1'b1) : SW'(v_ff);
      mag_old = old_ff[SW-1] ? SW'(~old_ff + 1'b1) : SW'(old_ff);
      sq_v    = mag_v * mag_v;
      sq_old  = mag_old * mag_old;
      fill_s1 = v_ff * $signed({1'b0, n_ff});
      fill_s2 = sqv_ff * n_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mwsd_pkg::ST_IDLE: begin
            if (accept && err_mode_ff) begin
               state_in = mwsd_pkg::ST_SQV;
            end
         end
         mwsd_pkg::ST_SQV: begin
            state_in = started_ff ? mwsd_pkg::ST_PUSH_A : mwsd_pkg::ST_FILL;
         end
         mwsd_pkg::ST_FILL:   state_in = mwsd_pkg::ST_DECIDE;
         mwsd_pkg::ST_PUSH_A: state_in = mwsd_pkg::ST_PUSH_B;
         mwsd_pkg::ST_PUSH_B: state_in = mwsd_pkg::ST_PUSH_C;
         mwsd_pkg::ST_PUSH_C: begin
            state_in = flushing_ff ? mwsd_pkg::ST_FLUSH_CHK : mwsd_pkg::ST_DECIDE;
         end
         mwsd_pkg::ST_DECIDE: begin
            if (last_ff) begin
               state_in = mwsd_pkg::ST_FLUSH_CHK;
            end else if (pending_ff > lag) begin
               state_in = mwsd_pkg::ST_STD_WAIT;
            end else begin
               state_in = mwsd_pkg::ST_IDLE;
            end
         end
         mwsd_pkg::ST_FLUSH_CHK: begin
            state_in = (shifts_ff < need) ? mwsd_pkg::ST_PUSH_A : mwsd_pkg::ST_STD_WAIT;
         end
         mwsd_pkg::ST_STD_WAIT: begin
            if (std_done) begin
               state_in = mwsd_pkg::ST_EMIT;
            end
         end
         mwsd_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               if (flushing_ff && back_ff != '0) begin
                  state_in = mwsd_pkg::ST_FLUSH_CHK;
               end else begin
                  state_in = mwsd_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mwsd_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      std_start       = 1'b0;
      cell_ctrl.load  = 1'b0;
      cell_ctrl.shift = 1'b0;
      case (state_ff)
         mwsd_pkg::ST_IDLE:   req_tready = 1'b1;
         mwsd_pkg::ST_FILL:   cell_ctrl.load = 1'b1;
         mwsd_pkg::ST_PUSH_A: cell_ctrl.shift = 1'b1;
         mwsd_pkg::ST_DECIDE: std_start = !last_ff && (pending_ff > lag);
         mwsd_pkg::ST_FLUSH_CHK: std_start = !(shifts_ff < need);
         mwsd_pkg::ST_EMIT:   rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      err_mode_in = err_mode_ff;
      win_len_in  = win_len_ff;
      n_in        = n_ff;
      v_in        = v_ff;
      last_in     = last_ff;
      old_in      = old_ff;
      sqv_in      = sqv_ff;
      sqo_in      = sqo_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      started_in  = started_ff;
      flushing_in = flushing_ff;
      pending_in  = pending_ff;
      back_in     = back_ff;
      shifts_in   = shifts_ff;
      out_in      = out_ff;
      olast_in    = olast_ff;
      oend_in     = oend_ff;

      if (csr_we) begin
         case (csr_index)
            mwsd_pkg::REG_ERR_MODE:      err_mode_in = csr_wdata[0];
            mwsd_pkg::REG_WINDOW_LENGTH: win_len_in = csr_wdata;
            default:                     err_mode_in = err_mode_ff;
         endcase
      end

      case (state_ff)
         mwsd_pkg::ST_IDLE: begin
            if (accept) begin
               v_in    = req_tdata[SW-1:0];
               last_in = req_tlast;
               if (!started_ff) begin
                  n_in = n_clamped;
               end
            end
         end
         mwsd_pkg::ST_SQV: begin
            sqv_in = sq_v;
         end
         mwsd_pkg::ST_FILL: begin
            s1_in       = fill_s1[mwsd_pkg::SUM_W-1:0];
            s2_in       = fill_s2[mwsd_pkg::SUMSQ_W-1:0];
            started_in  = 1'b1;
            pending_in  = CW'(1);
         end
         mwsd_pkg::ST_PUSH_A: begin
            old_in = cell_q[tail_idx[mwsd_pkg::IDX_W-1:0]];
         end
         mwsd_pkg::ST_PUSH_B: begin
            sqo_in = sq_old;
            s1_in  = s1_ff + mwsd_pkg::SUM_W'(v_ff) - mwsd_pkg::SUM_W'(old_ff);
         end
         mwsd_pkg::ST_PUSH_C: begin
            s2_in = s2_ff + mwsd_pkg::SUMSQ_W'(sqv_ff) - mwsd_pkg::SUMSQ_W'(sqo_ff);
            if (!flushing_ff) begin
               pending_in = pending_ff + 1'b1;
            end
         end
         mwsd_pkg::ST_DECIDE: begin
            olast_in = 1'b1;
            oend_in  = 1'b0;
            if (last_ff) begin
               flushing_in = 1'b1;
               back_in     = pending_ff - 1'b1;
               shifts_in   = '0;
            end
         end
         mwsd_pkg::ST_FLUSH_CHK: begin
            if (shifts_ff < need) begin
               shifts_in = shifts_ff + 1'b1;
            end else begin
               olast_in = (back_ff == '0);
               oend_in  = (back_ff == '0);
            end
         end
         mwsd_pkg::ST_STD_WAIT: begin
            if (std_done) begin
               out_in = std_result;
            end
         end
         mwsd_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               if (flushing_ff) begin
                  if (back_ff == '0) begin
                     // Close the series.
                     flushing_in = 1'b0;
                     started_in  = 1'b0;
                     pending_in  = '0;
                     s1_in       = '0;
                     s2_in       = '0;
                  end else begin
                     back_in = back_ff - 1'b1;
                  end
               end else begin
                  pending_in = pending_ff - 1'b1;
               end
            end
         end
         default: begin
            out_in = out_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mwsd_pkg::ST_IDLE;
         err_mode_ff <= 1'b0;
         win_len_ff  <= NW'(5);
         n_ff        <= NW'(1);
         started_ff  <= 1'b0;
         flushing_ff <= 1'b0;
         pending_ff  <= '0;
         back_ff     <= '0;
         shifts_ff   <= '0;
         s1_ff       <= '0;
         s2_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         err_mode_ff <= err_mode_in;
         win_len_ff  <= win_len_in;
         n_ff        <= n_in;
         started_ff  <= started_in;
         flushing_ff <= flushing_in;
         pending_ff  <= pending_in;
         back_ff     <= back_in;
         shifts_ff   <= shifts_in;
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
      end
      v_ff     <= v_in;
      last_ff  <= last_in;
      old_ff   <= old_in;
      sqv_ff   <= sqv_in;
      sqo_ff   <= sqo_in;
      out_ff   <= out_in;
      olast_ff <= olast_in;
      oend_ff  <= oend_in;
   end

   assign rsp_tdata = {1'b0, out_ff};
   assign rsp_tlast = olast_ff;
   assign rsp_tuser = oend_ff;

   // No new request while a result is held.
   a_no_req_during_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

   // The final position's result is always the last of its request.
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("series end without last of run");

   // Owed results never exceed the lag plus one.
   a_pending_bound : assert property (@(posedge clock) disable iff (reset)
      started_ff |-> ({1'b0, pending_ff} <= ({1'b0, lag} + 1'b1)))
      else $error("pending count out of range");

   // Latched window size stays in range.
   a_n_range : assert property (@(posedge clock) disable iff (reset)
      (n_ff != '0) && (n_ff <= NW'(MW)))
      else $error("window size out of range");

   // A result is loaded only when the std-dev unit completes.
   a_emit_after_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(std_done))
      else $error("result shown without std-dev completion");

endmodule
